// File: hdl/phpl_pkg.sv
// ----------------------------------------------------------------------------
// phpl_pkg
// Shared types and constants for the probed hash property lookup block:
// store sizes, item codes, slot encoding and memory write port bundles.
// ----------------------------------------------------------------------------
package phpl_pkg;

   // Store sizes and the address widths that follow from them.
   localparam int ENTRIES    = 64;
   localparam int HASH_SLOTS = 128;
   localparam int KEY_BITS   = 32;
   localparam int ENTRY_AW   = $clog2(ENTRIES);
   localparam int SLOT_AW    = $clog2(HASH_SLOTS);

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_WRITE_ENTRY = 2'd0,
      OP_WRITE_SLOT  = 2'd1,
      OP_LOOKUP      = 2'd2
   } opcode_type;

   // Slot content codes.
   typedef enum logic [1:0] {
      SLOT_ENTRY   = 2'd0,
      SLOT_DELETED = 2'd1,
      SLOT_UNUSED  = 2'd2
   } slot_kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_USE_HASH       = 2'd0,
      CSR_HASH_SIZE_LOG2 = 2'd1,
      CSR_ENTRIES_USED   = 2'd2
   } csr_index_type;

   // One entry of the entry store.
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [7:0]          attrs;
   } entry_type;

   // One hash slot.
   typedef struct packed {
      slot_kind_type       kind;
      logic [ENTRY_AW-1:0] entry;
   } slot_type;

   // Write port bundles.
   typedef struct packed {
      logic                en;
      logic [ENTRY_AW-1:0] addr;
      entry_type           data;
   } entry_wr_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_AW-1:0] addr;
      slot_type           data;
   } slot_wr_type;

endpackage

// File: hdl/phpl_entry_ram.sv
// ----------------------------------------------------------------------------
// phpl_entry_ram
// Entry store: key and attribute byte per entry, one write port and one
// read port with registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module phpl_entry_ram (
   input  logic                           clock,
   input  phpl_pkg::entry_wr_type         wr,
   input  logic                           rd_en,
   input  logic [phpl_pkg::ENTRY_AW-1:0]  rd_addr,
   output phpl_pkg::entry_type            rd_data
);
   import phpl_pkg::*;

   entry_type mem_ff [ENTRIES];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/phpl_slot_ram.sv
// ----------------------------------------------------------------------------
// phpl_slot_ram
// Hash slot store with one write port and one registered read port. A valid
// bit per slot, cleared by reset, makes every slot read as unused until it
// has been written.
// ----------------------------------------------------------------------------
module phpl_slot_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  phpl_pkg::slot_wr_type         wr,
   input  logic                          rd_en,
   input  logic [phpl_pkg::SLOT_AW-1:0]  rd_addr,
   output phpl_pkg::slot_type            rd_data
);
   import phpl_pkg::*;

   slot_type               mem_ff [HASH_SLOTS];
   logic [HASH_SLOTS-1:0]  valid_ff;
   slot_type               rd_data_ff;
   logic                   rd_valid_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Valid bits: cleared at once by reset, set by the first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // A slot never written reads as unused.
   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data.kind  = SLOT_UNUSED;
         rd_data.entry = '0;
      end
   end

endmodule

// File: hdl/probed_hash_property_lookup.sv
// ----------------------------------------------------------------------------
// probed_hash_property_lookup
// Key lookup over an entry store, either by direct scan or by linear probing
// of a hash slot store, with load items that write entries and slots.
// ----------------------------------------------------------------------------
// Every item gives exactly one result, shown for one cycle on rsp_strobe in
// the cycle after the item finishes; the receiver cannot stall it. Load
// items, unknown codes and lookups with no table finish at once, so their
// result appears in the cycle after start and the next item may follow
// straight away. A direct-scan lookup reads one entry per cycle from the
// entry store. A hash lookup first issues the first slot read, then steps
// past each deleted slot and, for each slot that points at an entry, reads
// the slot, then reads the entry and compares the key, bounded by one full
// pass of the slots in use. busy is high while a lookup is in progress.
// Configuration is written while the block is idle: a rule that binds the
// user, since the block itself leaves it unchecked. csr_ready is always
// high.
// ----------------------------------------------------------------------------
module probed_hash_property_lookup (
   input  logic        clock,
   input  logic        reset,
   // Item input
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_search_key,
   input  logic [31:0] req_key_hash,
   input  logic [7:0]  req_entry_attributes,
   input  logic [1:0]  req_slot_kind,
   input  logic [5:0]  req_slot_entry,
   // Results
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [5:0]  rsp_entry_index,
   output logic [6:0]  rsp_slot_index,
   output logic        rsp_slot_index_valid,
   output logic [7:0]  rsp_hit_attributes,
   output logic        rsp_probe_overflow,
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import phpl_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SCAN     = 5'b00010,
      ST_SLOT_RD  = 5'b00100,
      ST_SLOT_CHK = 5'b01000,
      ST_ENT_CHK  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;

   // Configuration registers.
   logic                   use_hash_ff;
   logic [2:0]             size_log2_ff;
   logic [6:0]             entries_used_ff;

   // Lookup working registers.
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [ENTRY_AW:0]      rd_idx_ff, rd_idx_in;
   logic [ENTRY_AW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [SLOT_AW-1:0]     slot_idx_ff, slot_idx_in;
   logic [SLOT_AW:0]       probe_cnt_ff, probe_cnt_in;
   logic [ENTRY_AW-1:0]    ent_idx_ff, ent_idx_in;

   // Result registers.
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   found_ff, found_in;
   logic [5:0]             entry_index_ff, entry_index_in;
   logic [6:0]             slot_index_ff, slot_index_in;
   logic                   slot_valid_ff, slot_valid_in;
   logic [7:0]             attrs_ff, attrs_in;
   logic                   overflow_ff, overflow_in;

   // Memory ports.
   entry_wr_type           entry_wr;
   logic                   entry_rd_en;
   logic [ENTRY_AW-1:0]    entry_rd_addr;
   entry_type              entry_q;
   slot_wr_type            slot_wr;
   logic                   slot_rd_en;
   logic [SLOT_AW-1:0]     slot_rd_addr;
   slot_type               slot_q;

   // Derived lookup limits.
   logic [ENTRY_AW:0]      entries_lim;
   logic [SLOT_AW:0]       slot_count;
   logic [SLOT_AW-1:0]     slot_mask;
   logic [SLOT_AW-1:0]     slot_next;
   logic                   pass_done;

   phpl_entry_ram u_entry_ram (
      .clock   (clock),
      .wr      (entry_wr),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_q)
   );

   phpl_slot_ram u_slot_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (slot_wr),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_q)
   );

   // Entry count saturates at the store size; slot count and mask follow
   // from the size register.
   assign entries_lim = (entries_used_ff > 7'(ENTRIES)) ? (ENTRY_AW+1)'(ENTRIES)
                                                        : (ENTRY_AW+1)'(entries_used_ff);
   assign slot_count  = (SLOT_AW+1)'(1) << size_log2_ff;
   assign slot_mask   = SLOT_AW'(slot_count - 1'b1);
   assign slot_next   = (slot_idx_ff + 1'b1) & slot_mask;
   assign pass_done   = ((probe_cnt_ff + 1'b1) == slot_count);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         use_hash_ff     <= 1'b0;
         size_log2_ff    <= 3'd7;
         entries_used_ff <= 7'd0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_USE_HASH:       use_hash_ff     <= csr_wdata[0];
            CSR_HASH_SIZE_LOG2: size_log2_ff    <= csr_wdata[2:0];
            CSR_ENTRIES_USED:   entries_used_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Sequencer: load items, direct scan and slot probing.
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      rd_pend_in    = rd_pend_ff;
      slot_idx_in   = slot_idx_ff;
      probe_cnt_in  = probe_cnt_ff;
      ent_idx_in    = ent_idx_ff;

      rsp_strobe_in  = 1'b0;
      found_in       = 1'b0;
      entry_index_in = '0;
      slot_index_in  = '0;
      slot_valid_in  = 1'b0;
      attrs_in       = '0;
      overflow_in    = 1'b0;

      entry_wr.en         = 1'b0;
      entry_wr.addr       = req_position[ENTRY_AW-1:0];
      entry_wr.data.key   = KEY_BITS'(req_search_key);
      entry_wr.data.attrs = req_entry_attributes;
      slot_wr.en          = 1'b0;
      slot_wr.addr        = req_position[SLOT_AW-1:0];
      slot_wr.data.kind   = slot_kind_type'(req_slot_kind);
      slot_wr.data.entry  = ENTRY_AW'(req_slot_entry);

      entry_rd_en   = 1'b0;
      entry_rd_addr = rd_idx_ff[ENTRY_AW-1:0];
      slot_rd_en    = 1'b0;
      slot_rd_addr  = slot_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_WRITE_ENTRY: begin
                     entry_wr.en   = (32'(req_position) < ENTRIES);
                     rsp_strobe_in = 1'b1;
                  end
                  OP_WRITE_SLOT: begin
                     slot_wr.en    = (32'(req_position) < HASH_SLOTS) &&
                                     (req_slot_kind != 2'd3);
                     rsp_strobe_in = 1'b1;
                  end
                  OP_LOOKUP: begin
                     key_in = KEY_BITS'(req_search_key);
                     if (entries_lim == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else if (use_hash_ff) begin
                        slot_idx_in  = req_key_hash[SLOT_AW-1:0] & slot_mask;
                        probe_cnt_in = '0;
                        state_in     = ST_SLOT_RD;
                     end else begin
                        rd_idx_in  = '0;
                        rd_pend_in = 1'b0;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // Direct scan: one entry read issued per cycle, compared the next.
         ST_SCAN: begin
            if (rd_pend_ff && (entry_q.key == key_ff)) begin
               rsp_strobe_in  = 1'b1;
               found_in       = 1'b1;
               entry_index_in = 6'(cmp_idx_ff);
               attrs_in       = entry_q.attrs;
               state_in       = ST_IDLE;
            end else if (rd_pend_ff &&
                         ((ENTRY_AW+1)'(cmp_idx_ff) == entries_lim - 1'b1)) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else if (rd_idx_ff < entries_lim) begin
               entry_rd_en = 1'b1;
               cmp_idx_in  = rd_idx_ff[ENTRY_AW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
               rd_pend_in  = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
         end

         // First slot read of a probe sequence.
         ST_SLOT_RD: begin
            slot_rd_en = 1'b1;
            state_in   = ST_SLOT_CHK;
         end

         // Slot data is here: follow an entry, skip a deleted slot or stop.
         ST_SLOT_CHK: begin
            case (slot_q.kind)
               SLOT_ENTRY: begin
                  entry_rd_en   = 1'b1;
                  entry_rd_addr = slot_q.entry;
                  ent_idx_in    = slot_q.entry;
                  state_in      = ST_ENT_CHK;
               end
               SLOT_DELETED: begin
                  if (pass_done) begin
                     rsp_strobe_in = 1'b1;
                     overflow_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     slot_idx_in  = slot_next;
                     slot_rd_en   = 1'b1;
                     slot_rd_addr = slot_next;
                     probe_cnt_in = probe_cnt_ff + 1'b1;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end

         // Entry data is here: compare the key, else go on to the next slot or stop after a full pass.
         ST_ENT_CHK: begin
            if (entry_q.key == key_ff) begin
               rsp_strobe_in  = 1'b1;
               found_in       = 1'b1;
               entry_index_in = 6'(ent_idx_ff);
               slot_index_in  = 7'(slot_idx_ff);
               slot_valid_in  = 1'b1;
               attrs_in       = entry_q.attrs;
               state_in       = ST_IDLE;
            end else if (pass_done) begin
               rsp_strobe_in = 1'b1;
               overflow_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               slot_idx_in  = slot_next;
               slot_rd_en   = 1'b1;
               slot_rd_addr = slot_next;
               probe_cnt_in = probe_cnt_ff + 1'b1;
               state_in     = ST_SLOT_CHK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      slot_idx_ff  <= slot_idx_in;
      probe_cnt_ff <= probe_cnt_in;
      ent_idx_ff   <= ent_idx_in;
      if (rsp_strobe_in) begin
         found_ff       <= found_in;
         entry_index_ff <= entry_index_in;
         slot_index_ff  <= slot_index_in;
         slot_valid_ff  <= slot_valid_in;
         attrs_ff       <= attrs_in;
         overflow_ff    <= overflow_in;
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_found            = found_ff;
   assign rsp_entry_index      = entry_index_ff;
   assign rsp_slot_index       = slot_index_ff;
   assign rsp_slot_index_valid = slot_valid_ff;
   assign rsp_hit_attributes   = attrs_ff;
   assign rsp_probe_overflow   = overflow_ff;

endmodule

// File: tb/probed_hash_property_lookup_tb.sv
// ----------------------------------------------------------------------------
// probed_hash_property_lookup_tb
// Self-checking testbench for the probed hash property lookup block. Entry
// writes, slot writes and key lookups are sent through the start/busy port,
// each accepted item is run through a lookup predictor kept in step with the
// block, and every strobed result is compared with the oldest predicted
// answer. Directed tests cover direct scans, probing with wraparound,
// deleted and unused slots and full-pass overflow; random traffic then runs
// under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module probed_hash_property_lookup_tb;

   import phpl_pkg::*;

   // Codes outside the defined sets, used to check that they are ignored.
   localparam logic [1:0] OP_UNKNOWN    = 2'd3;
   localparam logic [1:0] SLOT_KIND_BAD = 2'd3;

   // About 1550 items, each at worst a full pass of 128 slots plus a sender gap.
   localparam int CYCLE_LIMIT = 2_000_000;

   localparam int PHASE_ITEMS = 180;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  position;
      logic [31:0] search_key;
      logic [31:0] key_hash;
      logic [7:0]  attrs;
      logic [1:0]  slot_kind;
      logic [5:0]  slot_entry;
   } lookup_cmd_type;

   typedef struct packed {
      logic       found;
      logic [5:0] entry_index;
      logic [6:0] slot_index;
      logic       slot_index_valid;
      logic [7:0] hit_attributes;
      logic       probe_overflow;
   } lookup_answer_type;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   lookup_cmd_type drive_cmd;
   logic           rsp_strobe;
   logic           rsp_found;
   logic [5:0]     rsp_entry_index;
   logic [6:0]     rsp_slot_index;
   logic           rsp_slot_index_valid;
   logic [7:0]     rsp_hit_attributes;
   logic           rsp_probe_overflow;
   logic           csr_valid;
   logic           csr_ready;
   logic [1:0]     csr_index;
   logic [6:0]     csr_wdata;

   // Predictor copy of the stores and the registers.
   logic [31:0]   model_keys [ENTRIES];
   logic [7:0]    model_attrs [ENTRIES];
   slot_kind_type model_slot_kind [HASH_SLOTS];
   logic [5:0]    model_slot_ptr [HASH_SLOTS];
   logic          cfg_use_hash     = 1'b0;
   logic [2:0]    cfg_size_log2    = 3'd7;
   logic [6:0]    cfg_entries_used = 7'd0;

   lookup_answer_type pending_answers [$];
   int                mismatches   = 0;
   int                items_sent   = 0;
   int                idle_percent = 0;
   int                cycle_count  = 0;

   probed_hash_property_lookup i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (drive_cmd.opcode),
      .req_position         (drive_cmd.position),
      .req_search_key       (drive_cmd.search_key),
      .req_key_hash         (drive_cmd.key_hash),
      .req_entry_attributes (drive_cmd.attrs),
      .req_slot_kind        (drive_cmd.slot_kind),
      .req_slot_entry       (drive_cmd.slot_entry),
      .rsp_strobe           (rsp_strobe),
      .rsp_found            (rsp_found),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_slot_index_valid (rsp_slot_index_valid),
      .rsp_hit_attributes   (rsp_hit_attributes),
      .rsp_probe_overflow   (rsp_probe_overflow),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Works out the answer to one item and applies its writes to the copy.
   function automatic lookup_answer_type predict_answer(input lookup_cmd_type cmd);
      lookup_answer_type ans;
      int unsigned       scan_len;
      int unsigned       size;
      int unsigned       idx;
      int unsigned       i;
      ans = '0;
      case (cmd.opcode)
         OP_WRITE_ENTRY: begin
            if (cmd.position < ENTRIES) begin
               model_keys[cmd.position]  = cmd.search_key;
               model_attrs[cmd.position] = cmd.attrs;
            end
         end
         OP_WRITE_SLOT: begin
            // Every 7-bit position lies inside the slot store.
            if (cmd.slot_kind == SLOT_ENTRY) begin
               model_slot_kind[cmd.position] = SLOT_ENTRY;
               model_slot_ptr[cmd.position]  = cmd.slot_entry;
            end else if (cmd.slot_kind == SLOT_DELETED || cmd.slot_kind == SLOT_UNUSED) begin
               model_slot_kind[cmd.position] = slot_kind_type'(cmd.slot_kind);
            end
         end
         OP_LOOKUP: begin
            scan_len = (cfg_entries_used > ENTRIES) ? ENTRIES : cfg_entries_used;
            if (scan_len == 0)
               return ans;
            // Direct mode: the first equal key among the scanned entries wins.
            if (!cfg_use_hash) begin
               for (i = 0; i < scan_len; i++) begin
                  if (model_keys[i] == cmd.search_key) begin
                     ans.found          = 1'b1;
                     ans.entry_index    = 6'(i);
                     ans.hit_attributes = model_attrs[i];
                     return ans;
                  end
               end
               return ans;
            end
            // Hash mode: linear probing with wraparound, at most one full pass.
            size = 1 << cfg_size_log2;
            idx  = cmd.key_hash & (size - 1);
            for (i = 0; i < size; i++) begin
               if (model_slot_kind[idx] == SLOT_ENTRY) begin
                  if (model_keys[model_slot_ptr[idx]] == cmd.search_key) begin
                     ans.found            = 1'b1;
                     ans.entry_index      = model_slot_ptr[idx];
                     ans.slot_index       = 7'(idx);
                     ans.slot_index_valid = 1'b1;
                     ans.hit_attributes   = model_attrs[model_slot_ptr[idx]];
                     return ans;
                  end
               end else if (model_slot_kind[idx] == SLOT_UNUSED) begin
                  return ans;
               end
               idx = (idx + 1) & (size - 1);
            end
            ans.probe_overflow = 1'b1;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic string answer_text(input lookup_answer_type a);
      return $sformatf("found=%0b entry=%0d slot=%0d slot_valid=%0b attrs=%02h overflow=%0b",
                       a.found, a.entry_index, a.slot_index, a.slot_index_valid,
                       a.hit_attributes, a.probe_overflow);
   endfunction

   // Checks each strobed result, tracks register writes and predicts each
   // accepted item, in that order on each rising clock edge.
   always @(posedge clock) begin : result_watch
      lookup_answer_type seen;
      lookup_answer_type wanted;
      if (!reset) begin
         if (rsp_strobe) begin
            seen = {rsp_found, rsp_entry_index, rsp_slot_index, rsp_slot_index_valid,
                    rsp_hit_attributes, rsp_probe_overflow};
            if (pending_answers.size() == 0) begin
               if (mismatches < 10)
                  $display("Result with no item pending: %s", answer_text(seen));
               mismatches++;
            end else begin
               wanted = pending_answers.pop_front();
               if (seen !== wanted) begin
                  if (mismatches < 10)
                     $display("Result mismatch\n  expected %s\n  actual   %s",
                              answer_text(wanted), answer_text(seen));
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USE_HASH:       cfg_use_hash     = csr_wdata[0];
               CSR_HASH_SIZE_LOG2: cfg_size_log2    = csr_wdata[2:0];
               CSR_ENTRIES_USED:   cfg_entries_used = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            pending_answers.push_back(predict_answer(drive_cmd));
      end
   end

   // Item builders. Fields that an operation does not use carry random values.
   function automatic lookup_cmd_type noise_cmd();
      lookup_cmd_type c;
      c.opcode     = 2'($urandom);
      c.position   = 7'($urandom);
      c.search_key = $urandom;
      c.key_hash   = $urandom;
      c.attrs      = 8'($urandom);
      c.slot_kind  = 2'($urandom);
      c.slot_entry = 6'($urandom);
      return c;
   endfunction

   function automatic lookup_cmd_type entry_write_cmd(input int pos, input logic [31:0] key,
                                                      input logic [7:0] attrs);
      lookup_cmd_type c;
      c            = noise_cmd();
      c.opcode     = OP_WRITE_ENTRY;
      c.position   = 7'(pos);
      c.search_key = key;
      c.attrs      = attrs;
      return c;
   endfunction

   function automatic lookup_cmd_type slot_write_cmd(input int pos, input logic [1:0] kind,
                                                     input int entry);
      lookup_cmd_type c;
      c            = noise_cmd();
      c.opcode     = OP_WRITE_SLOT;
      c.position   = 7'(pos);
      c.slot_kind  = kind;
      c.slot_entry = 6'(entry);
      return c;
   endfunction

   function automatic lookup_cmd_type lookup_cmd(input logic [31:0] key,
                                                 input logic [31:0] hash);
      lookup_cmd_type c;
      c            = noise_cmd();
      c.opcode     = OP_LOOKUP;
      c.search_key = key;
      c.key_hash   = hash;
      return c;
   endfunction

   // Sends one item. Called and returning just after a falling edge.
   task automatic send_cmd(input lookup_cmd_type cmd);
      int unsigned gap;
      if ($urandom_range(0, 99) < idle_percent) begin
         gap   = $urandom_range(1, 4);
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      drive_cmd = cmd;
      start     = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      @(negedge clock);
      items_sent++;
   endtask

   // Holds off the sender until every pending answer has been checked.
   task automatic drain_results();
      start = 1'b0;
      while (pending_answers.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [6:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      @(negedge clock);
   endtask

   task automatic configure(input int use_hash, input int size_log2, input int entries_used);
      drain_results();
      write_register(CSR_USE_HASH, 7'(use_hash));
      write_register(CSR_HASH_SIZE_LOG2, 7'(size_log2));
      write_register(CSR_ENTRIES_USED, 7'(entries_used));
      csr_valid = 1'b0;
   endtask

   // Every entry is written before any lookup, so no scan or probe ever
   // reads an entry that holds nothing.
   task automatic load_entry_store();
      int p;
      for (p = 0; p < ENTRIES; p++) begin
         if (p == 0)
            send_cmd(entry_write_cmd(p, 32'h0000_0000, 8'hFF));
         else if (p == 1)
            send_cmd(entry_write_cmd(p, 32'hFFFF_FFFF, 8'h00));
         else
            send_cmd(entry_write_cmd(p, $urandom, 8'($urandom)));
      end
   endtask

   task automatic test_direct_scan();
      logic [31:0]    stray_key;
      lookup_cmd_type stray_cmd;
      stray_key    = $urandom;
      idle_percent = 0;
      configure(0, 7, 64);
      // Hits on the first and last entries, and on the key extremes.
      send_cmd(lookup_cmd(32'h0000_0000, $urandom));
      send_cmd(lookup_cmd(32'hFFFF_FFFF, $urandom));
      send_cmd(lookup_cmd(model_keys[63], $urandom));
      // A duplicate key further up must lose to the first equal entry.
      send_cmd(entry_write_cmd(10, model_keys[3], 8'h5A));
      send_cmd(lookup_cmd(model_keys[3], $urandom));
      // Writes beyond the entry store are dropped.
      send_cmd(entry_write_cmd(64, stray_key, 8'h11));
      send_cmd(entry_write_cmd(127, stray_key, 8'h22));
      send_cmd(lookup_cmd(stray_key, $urandom));
      // An unknown operation code is ignored.
      stray_cmd        = noise_cmd();
      stray_cmd.opcode = OP_UNKNOWN;
      send_cmd(stray_cmd);
      // A count above the store size saturates; small counts cut the scan short.
      configure(0, 7, 127);
      send_cmd(lookup_cmd(model_keys[63], $urandom));
      configure(0, 7, 1);
      send_cmd(lookup_cmd(model_keys[5], $urandom));
      configure(0, 7, 0);
      send_cmd(lookup_cmd(32'h0000_0000, $urandom));
   endtask

   task automatic test_hash_probe();
      int s;
      idle_percent = 0;
      configure(1, 3, 64);
      // Slots 5 to 0 of an eight-slot table: entry, deleted, entry, then wrap.
      send_cmd(slot_write_cmd(5, SLOT_ENTRY, 7));
      send_cmd(slot_write_cmd(6, SLOT_DELETED, 0));
      send_cmd(slot_write_cmd(7, SLOT_ENTRY, 9));
      send_cmd(slot_write_cmd(0, SLOT_ENTRY, 2));
      send_cmd(lookup_cmd(model_keys[9], 32'hFFFF_FFFD));
      send_cmd(lookup_cmd(model_keys[2], 32'h0000_0005));
      send_cmd(lookup_cmd(model_keys[20], 32'h0000_0005));
      // An invalid slot kind leaves the slot as it was.
      send_cmd(slot_write_cmd(1, SLOT_KIND_BAD, 0));
      // With no unused slot left a miss takes a full pass and overflows.
      for (s = 1; s <= 4; s++)
         send_cmd(slot_write_cmd(s, SLOT_DELETED, s));
      send_cmd(lookup_cmd(model_keys[20], 32'h0000_0000));
      // A one-slot table.
      configure(1, 0, 64);
      send_cmd(lookup_cmd(model_keys[2], 32'hFFFF_FFFF));
      send_cmd(lookup_cmd(model_keys[20], $urandom));
      // The full table: miss on an unused last slot, then a hit there.
      configure(1, 7, 64);
      send_cmd(lookup_cmd(model_keys[20], 32'h0000_007F));
      send_cmd(slot_write_cmd(127, SLOT_ENTRY, 63));
      send_cmd(lookup_cmd(model_keys[63], 32'hFFFF_FFFF));
      // No table at all in hash mode.
      configure(1, 7, 0);
      send_cmd(lookup_cmd(model_keys[63], 32'h0000_007F));
   endtask

   // Random traffic over several register settings and idle rates. Most of
   // it is lookups and complete insert-then-find sequences.
   task automatic test_random_traffic();
      int             ph_hash [8] = '{0, 1, 1, 1, 0, 1, 1, 0};
      int             ph_log2 [8] = '{7, 2, 0, 7, 4, 4, 3, 1};
      int             ph_used [8] = '{64, 64, 64, 127, 40, 64, 1, 127};
      int             ph_idle [8] = '{0, 60, 0, 33, 60, 33, 0, 60};
      int             ph;
      int             target;
      int             r;
      int             k;
      int             j;
      int             p;
      int             d;
      int unsigned    mask;
      logic [31:0]    key;
      logic [31:0]    hash;
      lookup_cmd_type c;
      for (ph = 0; ph < 8; ph++) begin
         idle_percent = 0;
         configure(ph_hash[ph], ph_log2[ph], ph_used[ph]);
         idle_percent = ph_idle[ph];
         mask         = (1 << cfg_size_log2) - 1;
         target       = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            // Once, pause the sender mid-phase until all answers are in.
            if (ph == 3 && items_sent == target - PHASE_ITEMS / 2)
               drain_results();
            r = $urandom_range(0, 99);
            if (r < 28) begin
               send_cmd(lookup_cmd(model_keys[$urandom_range(0, ENTRIES - 1)], $urandom));
            end else if (r < 38) begin
               send_cmd(lookup_cmd($urandom, $urandom));
            end else if (r < 56) begin
               p = ($urandom_range(0, 9) < 7) ? $urandom_range(0, mask) : $urandom_range(0, 127);
               k = $urandom_range(0, 9);
               if (k < 5)
                  send_cmd(slot_write_cmd(p, SLOT_ENTRY, $urandom_range(0, 63)));
               else if (k < 7)
                  send_cmd(slot_write_cmd(p, SLOT_DELETED, $urandom_range(0, 63)));
               else if (k < 9)
                  send_cmd(slot_write_cmd(p, SLOT_UNUSED, $urandom_range(0, 63)));
               else
                  send_cmd(slot_write_cmd(p, SLOT_KIND_BAD, $urandom_range(0, 63)));
            end else if (r < 68) begin
               p   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 63) : $urandom_range(64, 127);
               key = ($urandom_range(0, 4) == 0) ? model_keys[$urandom_range(0, 63)] : $urandom;
               send_cmd(entry_write_cmd(p, key, 8'($urandom)));
            end else if (r < 70) begin
               c        = noise_cmd();
               c.opcode = OP_UNKNOWN;
               send_cmd(c);
            end else begin
               // Insert a key a few probes away from its home slot, then find it.
               p    = $urandom_range(0, 63);
               key  = $urandom;
               hash = $urandom;
               d    = $urandom_range(0, (mask < 3) ? mask : 3);
               send_cmd(entry_write_cmd(p, key, 8'($urandom)));
               for (j = 0; j < d; j++)
                  send_cmd(slot_write_cmd((hash + j) & mask,
                                          $urandom_range(0, 1) ? SLOT_DELETED : SLOT_ENTRY,
                                          $urandom_range(0, 63)));
               send_cmd(slot_write_cmd((hash + d) & mask, SLOT_ENTRY, p));
               send_cmd(lookup_cmd(key, hash));
            end
         end
      end
   endtask

   // Test sequence.
   initial begin
      int s;
      for (s = 0; s < HASH_SLOTS; s++) begin
         model_slot_kind[s] = SLOT_UNUSED;
         model_slot_ptr[s]  = '0;
      end
      for (s = 0; s < ENTRIES; s++) begin
         model_keys[s]  = '0;
         model_attrs[s] = '0;
      end
      reset     = 1'b1;
      start     = 1'b0;
      drive_cmd = '0;
      csr_valid = 1'b0;
      csr_index = CSR_USE_HASH;
      csr_wdata = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      load_entry_store();
      test_direct_scan();
      test_hash_probe();
      test_random_traffic();

      drain_results();
      repeat (16) @(negedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
